// File: rtl/core/pidi_pkg.sv
`default_nettype none

package pidi_pkg;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 31;

  localparam logic [CfgIdxW-1:0] CFG_P_GAIN         = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_I_GAIN         = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_D_GAIN         = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_DEAD_BAND      = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_INTEGRAL_BAND  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_INTEGRAL_LIMIT = 3'd5;

  localparam logic [15:0] IntegralBandReset  = 16'd800;
  localparam logic [30:0] IntegralLimitReset = 31'd1000000;

  // Item kinds carried on the input tuser
  localparam logic ACT_COMPUTE = 1'b0;
  localparam logic ACT_REINIT  = 1'b1;

  typedef struct packed {
    logic [15:0] p_gain;
    logic [15:0] i_gain;
    logic [15:0] d_gain;
    logic [15:0] dead_band;
    logic [15:0] integral_band;
    logic [30:0] integral_limit;
  } cfg_t;

  // After the input register: error and error difference
  typedef struct packed {
    logic        action;
    logic [16:0] err;
    logic [17:0] derr;
    logic [31:0] preset;
  } front_t;

  // After the multiplier stage
  typedef struct packed {
    logic        action;
    logic        held;
    logic        separated;
    logic [32:0] ip;
    logic [32:0] pp;
    logic [33:0] dp;
    logic [31:0] preset;
  } mul_t;

  // After the integrator stage: two partial sums of the drive value
  typedef struct packed {
    logic        held;
    logic [34:0] pd;
    logic [31:0] it;
  } integ_t;

endpackage

`default_nettype wire

// File: rtl/core/pidi_cfg.sv
`default_nettype none

module pidi_cfg
  import pidi_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 we_i,
  input  wire [CfgIdxW-1:0]   idx_i,
  input  wire [CfgDataW-1:0]  data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  // Write one register per enabled cycle, ignore unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.p_gain         <= '0;
      cfg_q.i_gain         <= '0;
      cfg_q.d_gain         <= '0;
      cfg_q.dead_band      <= '0;
      cfg_q.integral_band  <= IntegralBandReset;
      cfg_q.integral_limit <= IntegralLimitReset;
    end else if (we_i) begin
      unique case (idx_i)
        CFG_P_GAIN:         cfg_q.p_gain         <= data_i[15:0];
        CFG_I_GAIN:         cfg_q.i_gain         <= data_i[15:0];
        CFG_D_GAIN:         cfg_q.d_gain         <= data_i[15:0];
        CFG_DEAD_BAND:      cfg_q.dead_band      <= data_i[15:0];
        CFG_INTEGRAL_BAND:  cfg_q.integral_band  <= data_i[15:0];
        CFG_INTEGRAL_LIMIT: cfg_q.integral_limit <= data_i[30:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: rtl/core/pidi_front.sv
`default_nettype none

module pidi_front
  import pidi_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          adv_i,
  input  wire          in_valid_i,
  input  wire          action_i,
  input  wire [15:0]   measured_i,
  input  wire [15:0]   target_i,
  input  wire [31:0]   preset_i,
  output logic         a_valid_o,
  output front_t       a_o
);

  logic        a_valid_q;
  front_t      a_q;
  logic [17:0] prev_err_q;
  logic [16:0] err_w;
  logic [17:0] derr_w;

  // Form the error and its change against the last error
  assign err_w  = {target_i[15], target_i} - {measured_i[15], measured_i};
  assign derr_w = {err_w[16], err_w} - prev_err_q;

  // Advance the valid bit, track the last error on every accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q  <= 1'b0;
      prev_err_q <= '0;
    end else if (adv_i) begin
      a_valid_q <= in_valid_i;
      if (in_valid_i) begin
        prev_err_q <= {err_w[16], err_w};
      end
    end
  end

  // Capture payload
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_q.action <= action_i;
      a_q.err    <= err_w;
      a_q.derr   <= derr_w;
      a_q.preset <= preset_i;
    end
  end

  assign a_valid_o = a_valid_q;
  assign a_o       = a_q;

endmodule

`default_nettype wire

// File: rtl/core/pidi_mul.sv
`default_nettype none

module pidi_mul
  import pidi_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          adv_i,
  input  wire          a_valid_i,
  input  front_t       a_i,
  input  cfg_t         cfg_i,
  output logic         b_valid_o,
  output mul_t         b_o
);

  logic               b_valid_q;
  mul_t               b_q;
  logic [16:0]        mag_w;
  logic signed [33:0] ip_full;
  logic signed [33:0] pp_full;
  logic signed [34:0] dp_full;

  // Error magnitude against the two bands
  assign mag_w = a_i.err[16] ? (~a_i.err + 17'd1) : a_i.err;

  // Three independent gain products
  assign ip_full = $signed({1'b0, cfg_i.i_gain}) * $signed(a_i.err);
  assign pp_full = $signed({1'b0, cfg_i.p_gain}) * $signed(a_i.err);
  assign dp_full = $signed({1'b0, cfg_i.d_gain}) * $signed(a_i.derr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (adv_i) begin
      b_valid_q <= a_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      b_q.action    <= a_i.action;
      b_q.held      <= (mag_w <= {1'b0, cfg_i.dead_band});
      b_q.separated <= (mag_w > {1'b0, cfg_i.integral_band});
      b_q.ip        <= ip_full[32:0];
      b_q.pp        <= pp_full[32:0];
      b_q.dp        <= dp_full[33:0];
      b_q.preset    <= a_i.preset;
    end
  end

  assign b_valid_o = b_valid_q;
  assign b_o       = b_q;

endmodule

`default_nettype wire

// File: rtl/core/pidi_integ.sv
`default_nettype none

module pidi_integ
  import pidi_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          adv_i,
  input  wire          b_valid_i,
  input  mul_t         b_i,
  input  wire [30:0]   limit_i,
  output logic         c_valid_o,
  output integ_t       c_o
);

  logic               c_valid_q;
  integ_t             c_q;
  integ_t             c_d;
  logic [31:0]        integral_q;
  logic [31:0]        integral_d;
  logic signed [33:0] acc_w;
  logic signed [33:0] lim_w;
  logic signed [33:0] neg_lim_w;
  logic [31:0]        clamped_w;
  logic [34:0]        pd_w;

  // Accumulate and saturate to the symmetric limit
  assign acc_w     = $signed({{2{integral_q[31]}}, integral_q}) + $signed({b_i.ip[32], b_i.ip});
  assign lim_w     = $signed({3'b000, limit_i});
  assign neg_lim_w = -lim_w;

  always_comb begin
    priority if (acc_w > lim_w) begin
      clamped_w = lim_w[31:0];
    end else if (acc_w < neg_lim_w) begin
      clamped_w = neg_lim_w[31:0];
    end else begin
      clamped_w = acc_w[31:0];
    end
  end

  assign pd_w = {{2{b_i.pp[32]}}, b_i.pp} + {b_i.dp[33], b_i.dp};

  // Select the integral update and the drive partial sums
  always_comb begin
    integral_d = integral_q;
    c_d.held   = 1'b0;
    c_d.pd     = '0;
    c_d.it     = '0;
    priority if (b_i.action == ACT_REINIT) begin
      integral_d = b_i.preset;
    end else if (b_i.held) begin
      c_d.held = 1'b1;
      c_d.it   = integral_q;
    end else if (b_i.separated) begin
      integral_d = '0;
      c_d.pd     = pd_w;
    end else begin
      integral_d = clamped_w;
      c_d.pd     = pd_w;
      c_d.it     = clamped_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q  <= 1'b0;
      integral_q <= '0;
    end else if (adv_i) begin
      c_valid_q <= b_valid_i;
      if (b_valid_i) begin
        integral_q <= integral_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      c_q <= c_d;
    end
  end

  assign c_valid_o = c_valid_q;
  assign c_o       = c_q;

endmodule

`default_nettype wire

// File: rtl/core/pid_deadband_integral_separation.sv
`default_nettype none

// Positional PID controller with deadband and integral separation on values in
// hundredths. Each input transaction is either a control step or a reinit
// (tuser), and produces exactly one result transaction in order: the input
// register forms the error and its change, the next stage forms the three gain
// products, the next updates the integral accumulator, and the output register
// adds the drive value. One transaction is taken every cycle unless the pipe
// stalls; the only thing that stalls the pipe is an untaken result in the output
// register, and the single-stage integral update sets the rate of one item per cycle.
// Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_data_i
// and must only change while no transaction is in flight.
module pid_deadband_integral_separation
  import pidi_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  // Configuration write port
  input  wire                 cfg_we_i,
  input  wire [CfgIdxW-1:0]   cfg_idx_i,
  input  wire [CfgDataW-1:0]  cfg_data_i,
  // Input stream
  input  wire                 s_axis_tvalid,
  output logic                s_axis_tready,
  input  wire [63:0]          s_axis_tdata,   // measured_value[15:0], target_value[31:16],
                                              // preset_integral[63:32]
  input  wire                 s_axis_tuser,   // action
  // Result stream
  output logic                m_axis_tvalid,
  input  wire                 m_axis_tready,
  output logic [39:0]         m_axis_tdata,   // drive_value[35:0], zero[39:36]
  output logic                m_axis_tuser    // in_dead_band
);

  cfg_t        cfg;
  logic        adv;
  logic        a_valid;
  front_t      a;
  logic        b_valid;
  mul_t        b;
  logic        c_valid;
  integ_t      c;
  logic        out_valid_q;
  logic [35:0] drive_q;
  logic        held_q;
  logic [35:0] drive_d;

  // Move the whole pipe unless the result register holds an untaken result
  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;

  pidi_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  pidi_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_valid_i (s_axis_tvalid),
    .action_i   (s_axis_tuser),
    .measured_i (s_axis_tdata[15:0]),
    .target_i   (s_axis_tdata[31:16]),
    .preset_i   (s_axis_tdata[63:32]),
    .a_valid_o  (a_valid),
    .a_o        (a)
  );

  pidi_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .a_valid_i (a_valid),
    .a_i       (a),
    .cfg_i     (cfg),
    .b_valid_o (b_valid),
    .b_o       (b)
  );

  pidi_integ u_integ (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .b_valid_i (b_valid),
    .b_i       (b),
    .limit_i   (cfg.integral_limit),
    .c_valid_o (c_valid),
    .c_o       (c)
  );

  // Add the partial sums into the result register
  assign drive_d = {c.pd[34], c.pd} + {{4{c.it[31]}}, c.it};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= c_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      drive_q <= drive_d;
      held_q  <= c.held;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, drive_q};
  assign m_axis_tuser  = held_q;

endmodule

`default_nettype wire

// File: rtl/core/pidi_checker.sv
`default_nettype none

module pidi_checker (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 s_axis_tvalid,
  input wire                 s_axis_tready,
  input wire                 m_axis_tvalid,
  input wire                 m_axis_tready,
  input wire [39:0]          m_axis_tdata,
  input wire                 m_axis_tuser
);

  logic idle_cycle;

  // Pipe moving with nothing entering
  assign idle_cycle = s_axis_tready && !s_axis_tvalid;

  // Stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Input side only stalls behind an untaken result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  // Moving cycles with no transaction, one per pipe register, leave the pipe empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle_cycle && $past(idle_cycle, 1) && $past(idle_cycle, 2) && $past(idle_cycle, 3)
      |=> !m_axis_tvalid)
    else $error("result appeared without an input transaction");

  // Drive value upper pad bits stay zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[39:36] == 4'b0000)
    else $error("result padding not zero");

endmodule

bind pid_deadband_integral_separation pidi_checker u_pidi_checker (.*);

`default_nettype wire

// File: verif/tb.sv
module tb;
  import pidi_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int RAND_PHASES = 7;
  localparam int ITEMS_PER_PHASE = 155;
  // Index past the last register, used to check that stray writes are dropped
  localparam logic [CfgIdxW-1:0] CFG_UNMAPPED = 3'd6;

  typedef struct {
    logic               action;
    logic signed [15:0] measured;
    logic signed [15:0] target;
    logic signed [31:0] preset;
  } ctrl_item_t;

  typedef struct {
    logic [35:0] drive;
    logic        held;
  } drive_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [63:0]         s_axis_tdata;   // measured_value, target_value, preset_integral
  logic                s_axis_tuser;   // action
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [39:0]         m_axis_tdata;   // drive_value, zero pad
  logic                m_axis_tuser;   // in_dead_band

  // Controller state and settings as the block should hold them
  longint gain_p, gain_i, gain_d, dead_band_q, int_band_q, int_limit_q;
  longint integral_acc, last_error;

  drive_result_t drive_expected_q[$];
  int          fail_count = 0;
  int          result_count = 0;
  int          step_count = 0;
  int          reinit_count = 0;
  int          setting_count = 0;
  bit          tx_gaps_on = 1'b1;
  bit          rx_stalls_on = 1'b1;
  int          rx_stall_left = 0;
  int unsigned cycle_count = 0;

  pid_deadband_integral_separation DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, drive_expected_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(24, 4);
  endfunction

  // One control step: update integral and last error, return drive and hold flag
  function automatic drive_result_t pid_control_step(input ctrl_item_t it);
    drive_result_t res;
    longint err, err_mag, p_term, d_term, i_term, acc;
    err = longint'(it.target) - longint'(it.measured);
    err_mag = (err < 0) ? -err : err;
    res.drive = '0;
    res.held = 1'b0;
    if (it.action == ACT_REINIT) begin
      // Bumpless transfer: load the accumulator, seed last error, emit zero
      integral_acc = longint'(it.preset);
      last_error = err;
      return res;
    end
    if (err_mag <= dead_band_q) begin
      res.held = 1'b1;
      res.drive = integral_acc[35:0];
    end else begin
      p_term = gain_p * err;
      d_term = gain_d * (err - last_error);
      if (err_mag > int_band_q) begin
        integral_acc = 0;
        i_term = 0;
      end else begin
        acc = integral_acc + gain_i * err;
        if (acc > int_limit_q) acc = int_limit_q;
        if (acc < -int_limit_q) acc = -int_limit_q;
        integral_acc = acc;
        i_term = acc;
      end
      acc = p_term + i_term + d_term;
      res.drive = acc[35:0];
    end
    last_error = err;
    return res;
  endfunction

  function automatic ctrl_item_t mk_item(input logic action, input int meas, input int tgt,
                                         input logic signed [31:0] preset);
    ctrl_item_t it;
    it.action = action;
    it.measured = meas[15:0];
    it.target = tgt[15:0];
    it.preset = preset;
    return it;
  endfunction

  // Random item with its error steered toward the current band edges
  function automatic ctrl_item_t random_item();
    ctrl_item_t it;
    int mode, err, lo, hi, meas, tgt;
    longint near_lim;
    mode = $urandom_range(99);
    it.action = ($urandom_range(99) < 8) ? ACT_REINIT : ACT_COMPUTE;
    if (mode < 20) begin
      it.measured = 16'($urandom);
      it.target = 16'($urandom);
    end else begin
      if (mode < 55) err = int'(dead_band_q) + int'($urandom_range(4)) - 2;
      else if (mode < 85) err = int'($urandom_range(int'(int_band_q) + 2));
      else err = int'(int_band_q) + int'($urandom_range(4)) - 2;
      if (err < 0) err = 0;
      if (err > 65535) err = 65535;
      if ($urandom_range(1) == 1) err = -err;
      lo = (err > 0) ? -32768 : -32768 - err;
      hi = (err > 0) ? 32767 - err : 32767;
      meas = lo + int'($urandom_range(hi - lo));
      tgt = meas + err;
      it.measured = meas[15:0];
      it.target = tgt[15:0];
    end
    case ($urandom_range(2))
      0: it.preset = $urandom;
      1: it.preset = int'($urandom_range(40000)) - 20000;
      default: begin
        near_lim = int_limit_q + longint'($urandom_range(4)) - 2;
        if ($urandom_range(1) == 1) near_lim = -near_lim;
        it.preset = near_lim[31:0];
      end
    endcase
    if (it.preset == 32'sh8000_0000) it.preset = 32'sh8000_0001;
    return it;
  endfunction

  // Write one register and mirror it
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_P_GAIN:         gain_p = longint'(value[15:0]);
      CFG_I_GAIN:         gain_i = longint'(value[15:0]);
      CFG_D_GAIN:         gain_d = longint'(value[15:0]);
      CFG_DEAD_BAND:      dead_band_q = longint'(value[15:0]);
      CFG_INTEGRAL_BAND:  int_band_q = longint'(value[15:0]);
      CFG_INTEGRAL_LIMIT: int_limit_q = longint'(value[30:0]);
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [15:0] p, input logic [15:0] i, input logic [15:0] d,
                               input logic [15:0] dead, input logic [15:0] band,
                               input logic [30:0] limit);
    write_reg(CFG_P_GAIN, CfgDataW'(p));
    write_reg(CFG_I_GAIN, CfgDataW'(i));
    write_reg(CFG_D_GAIN, CfgDataW'(d));
    write_reg(CFG_DEAD_BAND, CfgDataW'(dead));
    write_reg(CFG_INTEGRAL_BAND, CfgDataW'(band));
    write_reg(CFG_INTEGRAL_LIMIT, limit);
    setting_count++;
  endtask

  // Present one item, hold it until the transaction completes, then predict
  task automatic send_item(input ctrl_item_t it);
    int gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.action;
    s_axis_tdata <= {it.preset, it.target, it.measured};
    do @(posedge clk_i); while (!s_axis_tready);
    drive_expected_q.push_back(pid_control_step(it));
    if (it.action == ACT_REINIT) reinit_count++;
    else step_count++;
  endtask

  // Drop valid, let every result come back, then let the pipe settle
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (drive_expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Randomly stall the result side
  always @(posedge clk_i) begin
    if (rx_stall_left == 0 && rx_stalls_on && $urandom_range(3) == 0) rx_stall_left = pick_gap();
    if (rx_stall_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin : check_result
    drive_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      result_count++;
      if (drive_expected_q.size() == 0) begin
        $display("%0t: unexpected result drive=%0d held=%0b", $time,
                 $signed(m_axis_tdata[35:0]), m_axis_tuser);
        fail_count++;
      end else begin
        exp_r = drive_expected_q.pop_front();
        if (m_axis_tdata[35:0] !== exp_r.drive) begin
          $display("%0t: drive_value expected %0d got %0d", $time,
                   $signed(exp_r.drive), $signed(m_axis_tdata[35:0]));
          fail_count++;
        end
        if (m_axis_tdata[39:36] !== 4'b0) begin
          $display("%0t: pad bits expected 0 got %h", $time, m_axis_tdata[39:36]);
          fail_count++;
        end
        if (m_axis_tuser !== exp_r.held) begin
          $display("%0t: in_dead_band expected %0b got %0b", $time, exp_r.held, m_axis_tuser);
          fail_count++;
        end
      end
    end
  end

  // Reset settings: zero gains, so only the integral state shows, through hold, reinit and separation
  task automatic test_reset_state();
    send_item(mk_item(ACT_COMPUTE, 0, 0, 0));
    send_item(mk_item(ACT_COMPUTE, 100, 900, 0));
    send_item(mk_item(ACT_REINIT, 40, 40, 12345));
    send_item(mk_item(ACT_COMPUTE, -7, -7, 0));
    send_item(mk_item(ACT_COMPUTE, -500, 301, 0));
    send_item(mk_item(ACT_COMPUTE, 3, 3, 0));
  endtask

  // Deadband and integral band edges, and the widest errors
  task automatic test_band_edges();
    wait_drained();
    apply_setting(16'd150, 16'd40, 16'd25, 16'd10, 16'd300, 31'd5000);
    send_item(mk_item(ACT_COMPUTE, 0, 10, 0));
    send_item(mk_item(ACT_COMPUTE, 10, 0, 0));
    send_item(mk_item(ACT_COMPUTE, 0, 11, 0));
    send_item(mk_item(ACT_COMPUTE, 11, 0, 0));
    send_item(mk_item(ACT_COMPUTE, -100, 200, 0));
    send_item(mk_item(ACT_COMPUTE, -100, 201, 0));
    send_item(mk_item(ACT_COMPUTE, 301, 0, 0));
    send_item(mk_item(ACT_COMPUTE, -32768, 32767, 0));
    send_item(mk_item(ACT_COMPUTE, 32767, -32768, 0));
  endtask

  // Reinit loads beyond the limit, clamping both ways, maximal settings
  task automatic test_saturation_and_reinit();
    send_item(mk_item(ACT_REINIT, 0, 5, 32'sh7FFF_FFFF));
    send_item(mk_item(ACT_COMPUTE, 0, 3, 0));
    send_item(mk_item(ACT_COMPUTE, 0, 200, 0));
    send_item(mk_item(ACT_REINIT, 5, 0, 32'sh8000_0001));
    send_item(mk_item(ACT_COMPUTE, 200, 0, 0));
    wait_drained();
    apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 31'h7FFF_FFFF);
    write_reg(CFG_UNMAPPED, CfgDataW'($urandom));
    send_item(mk_item(ACT_COMPUTE, -32768, 32767, 0));
    send_item(mk_item(ACT_COMPUTE, 32767, -32768, 0));
    send_item(mk_item(ACT_COMPUTE, 1234, 1234, 0));
    send_item(mk_item(ACT_REINIT, 32767, -32768, 32'sh8000_0001));
    send_item(mk_item(ACT_COMPUTE, 32767, -32768, 0));
    wait_drained();
    write_reg(CFG_INTEGRAL_LIMIT, '0);
    send_item(mk_item(ACT_COMPUTE, 0, 5, 0));
  endtask

  // Random traffic over fixed extremes and random settings
  task automatic test_random_phases();
    logic [15:0] dead, band;
    logic [30:0] limit;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 31'h7FFF_FFFF);
        1: apply_setting(16'd120, 16'd30, 16'd45, 16'hFFFF, 16'd500, 31'd100000);
        2: apply_setting(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 31'd0);
        default: begin
          dead = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40));
          band = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(3000));
          limit = ($urandom_range(1) == 0) ? 31'($urandom_range(20000)) : 31'($urandom);
          apply_setting(($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(300)),
                        ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(300)),
                        ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(300)),
                        dead, band, limit);
        end
      endcase
      tx_gaps_on = (ph % 3) != 1;
      rx_stalls_on = (ph % 4) != 2;
      repeat (ITEMS_PER_PHASE) send_item(random_item());
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_P_GAIN;
    cfg_data_i <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= ACT_COMPUTE;
    gain_p = 0;
    gain_i = 0;
    gain_d = 0;
    dead_band_q = 0;
    int_band_q = longint'(IntegralBandReset);
    int_limit_q = longint'(IntegralLimitReset);
    integral_acc = 0;
    last_error = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_band_edges();
    test_saturation_and_reinit();
    test_random_phases();
    wait_drained();

    $display("Ran %0d control steps and %0d reinit loads under %0d register settings,",
             step_count, reinit_count, setting_count + 1);
    $display("with random gaps and stalls on both streams; %0d results checked, %0d failures.",
             result_count, fail_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
